FILE: src/vgrt_pkg.sv
// Shared types and constants for the voxel grid ray traversal block.
package vgrt_pkg;

	localparam int CoordW  = 6;
	localparam int OriginW = 22;
	localparam int DirW    = 16;
	localparam int DistW   = 16;
	localparam int SideW   = 3;
	localparam int DirFrac = 14;
	localparam int CurW    = 16;
	localparam int TravW   = DistW + 1;
	localparam int LimW    = 10;

	localparam logic [SideW-1:0] SIDE_MISS = 3'd5;
	localparam logic [1:0]       AXIS_NONE = 2'd3;

	typedef struct packed {
		logic                      is_cast;
		logic                      wr_ok;
		logic [CoordW-1:0]         voxel_x;
		logic [CoordW-1:0]         voxel_y;
		logic [CoordW-1:0]         voxel_z;
		logic                      voxel_filled;
		logic [OriginW-1:0]        origin_x;
		logic [OriginW-1:0]        origin_y;
		logic [OriginW-1:0]        origin_z;
		logic signed [DirW-1:0]    dir_x;
		logic signed [DirW-1:0]    dir_y;
		logic signed [DirW-1:0]    dir_z;
		logic [DistW-1:0]          max_dist;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_out_t;

endpackage

FILE: src/vgrt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module vgrt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: src/vgrt_front.sv
// Front end: takes command transfers, classifies them and queues them for the walker.
module vgrt_front #(
	parameter int GRID_SIZE = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  vgrt_pkg::item_t     item_in,
	input  logic                clearing,
	input  logic                pop,
	output logic                busy,
	output vgrt_pkg::queue_out_t q_out
);

	import vgrt_pkg::*;

	item_t      ents_q [2];
	logic [1:0] cnt_q;
	logic       wp_q;
	logic       rp_q;
	logic       push;
	item_t      cls;

	assign busy = (cnt_q == 2'd2) || clearing;
	assign push = start && !busy;

	always_comb begin
		cls         = item_in;
		cls.wr_ok   = (32'(item_in.voxel_x) < 32'(GRID_SIZE))
		           && (32'(item_in.voxel_y) < 32'(GRID_SIZE))
		           && (32'(item_in.voxel_z) < 32'(GRID_SIZE));
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ents_q[wp_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	assign q_out.valid = (cnt_q != 2'd0);
	assign q_out.item  = ents_q[rp_q];

endmodule

FILE: src/vgrt_back.sv
// Back end: clears the grid, applies voxel writes and walks cast rays cell by cell.
module vgrt_back #(
	parameter int GRID_SIZE     = 64,
	parameter int POS_FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  vgrt_pkg::queue_out_t              q_in,
	output logic                              pop,
	output logic                              clearing,
	output logic                              done,
	output logic                              hit,
	output logic [vgrt_pkg::SideW-1:0]        hit_side,
	output logic [vgrt_pkg::CoordW-1:0]       hit_x,
	output logic [vgrt_pkg::CoordW-1:0]       hit_y,
	output logic [vgrt_pkg::CoordW-1:0]       hit_z,
	output logic [vgrt_pkg::DistW-1:0]        distance
);

	import vgrt_pkg::*;

	localparam int PW   = POS_FRAC_BITS + 1;
	localparam int NW   = POS_FRAC_BITS + 1 + DirFrac;
	localparam int RW   = POS_FRAC_BITS + 3;
	localparam int MvW  = POS_FRAC_BITS + 5;
	localparam int CW   = $clog2(NW + 1);
	localparam int RowN = GRID_SIZE * GRID_SIZE;
	localparam int AW   = $clog2(RowN);
	localparam int XW   = $clog2(GRID_SIZE);
	localparam logic [PW-1:0] OneV = PW'(1) << POS_FRAC_BITS;
	localparam logic [RW-1:0] RemInit = RW'(5) << POS_FRAC_BITS;

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_W_RD  = 4'd2;
	localparam logic [3:0] ST_W_WR  = 4'd3;
	localparam logic [3:0] ST_SQ    = 4'd4;
	localparam logic [3:0] ST_SQRT  = 4'd5;
	localparam logic [3:0] ST_LOOP  = 4'd6;
	localparam logic [3:0] ST_AX    = 4'd7;
	localparam logic [3:0] ST_DIV   = 4'd8;
	localparam logic [3:0] ST_DIVE  = 4'd9;
	localparam logic [3:0] ST_DIST  = 4'd10;
	localparam logic [3:0] ST_MOVE  = 4'd11;
	localparam logic [3:0] ST_CROSS = 4'd12;
	localparam logic [3:0] ST_RD    = 4'd13;
	localparam logic [3:0] ST_CHECK = 4'd14;

	logic [3:0]              state_q;
	logic [AW-1:0]           clr_q;
	logic signed [CurW-1:0]  cur_q [3];
	logic [PW-1:0]           p_q [3];
	logic [2:0]              neg_q;
	logic [DirW-1:0]         mag_q [3];
	logic [DistW-1:0]        maxd_q;
	logic [LimW-1:0]         lim_q;
	logic [LimW-1:0]         i_q;
	logic [31:0]             sq_q;
	logic [31:0]             r_q;
	logic [31:0]             bit_q;
	logic [DistW-1:0]        dlen_q;
	logic [TravW-1:0]        trav_q;
	logic [RW-1:0]           rem_q;
	logic [1:0]              axis_q;
	logic [1:0]              ax_q;
	logic [NW-1:0]           dn_q;
	logic [DirW-1:0]         dr_q;
	logic [CW-1:0]           dcnt_q;
	logic [AW-1:0]           row_q;
	logic [XW-1:0]           z_q;
	logic                    fill_q;
	logic                    ingrid_q;

	logic                    ram_we;
	logic [AW-1:0]           ram_waddr;
	logic [GRID_SIZE-1:0]    ram_wdata;
	logic                    ram_re;
	logic [AW-1:0]           ram_raddr;
	logic [GRID_SIZE-1:0]    ram_rdata;

	logic [1:0]              axi;
	logic [1:0]              axc;
	logic [PW-1:0]           gap;
	logic [DirW:0]           dtry;
	logic [31:0]             sq_sum;
	logic [RW+DistW-1:0]     prod_d;
	logic [TravW-1:0]        trav_n;
	logic [RW+DistW-1:0]     prod_m;
	logic [MvW-1:0]          mv;
	logic [MvW-1:0]          psum;
	logic [AW-1:0]           row_c;
	logic                    ingrid_c;

	function automatic logic in_grid(input logic signed [CurW-1:0] c);
		in_grid = !c[CurW-1] && (c < $signed(CurW'(GRID_SIZE)));
	endfunction

	vgrt_ram #(
		.WIDTH(GRID_SIZE),
		.DEPTH(RowN)
	) u_grid (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign clearing = (state_q == ST_CLEAR);
	assign pop      = (state_q == ST_IDLE) && q_in.valid;

	assign axi    = (ax_q == AXIS_NONE) ? 2'd0 : ax_q;
	assign axc    = (axis_q == AXIS_NONE) ? 2'd0 : axis_q;
	assign gap    = neg_q[axi] ? p_q[axi] : OneV - p_q[axi];
	assign dtry   = {dr_q, dn_q[NW-1]};
	assign sq_sum = r_q + bit_q;
	assign prod_d = (RW+DistW)'(rem_q) * (RW+DistW)'(dlen_q);
	assign trav_n = trav_q + TravW'(prod_d >> (POS_FRAC_BITS + DirFrac - 8));
	assign prod_m = (RW+DistW)'(rem_q) * (RW+DistW)'(mag_q[axi]);
	assign mv     = MvW'(prod_m >> DirFrac);
	assign psum   = MvW'(p_q[axi]) + mv;
	assign row_c  = AW'(unsigned'(cur_q[0][XW-1:0])) * AW'(GRID_SIZE)
	              + AW'(unsigned'(cur_q[1][XW-1:0]));
	assign ingrid_c = in_grid(cur_q[0]) && in_grid(cur_q[1]) && in_grid(cur_q[2]);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = row_q;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
			end
			ST_W_RD: begin
				ram_re = 1'b1;
			end
			ST_W_WR: begin
				ram_we         = 1'b1;
				ram_waddr      = row_q;
				ram_wdata      = ram_rdata;
				ram_wdata[z_q] = fill_q;
			end
			ST_RD: begin
				ram_re    = 1'b1;
				ram_raddr = row_c;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				row_q  <= AW'(q_in.item.voxel_x) * AW'(GRID_SIZE) + AW'(q_in.item.voxel_y);
				z_q    <= XW'(q_in.item.voxel_z);
				fill_q <= q_in.item.voxel_filled;
				cur_q[0] <= CurW'(q_in.item.origin_x >> POS_FRAC_BITS);
				cur_q[1] <= CurW'(q_in.item.origin_y >> POS_FRAC_BITS);
				cur_q[2] <= CurW'(q_in.item.origin_z >> POS_FRAC_BITS);
				p_q[0] <= PW'(q_in.item.origin_x[POS_FRAC_BITS-1:0]);
				p_q[1] <= PW'(q_in.item.origin_y[POS_FRAC_BITS-1:0]);
				p_q[2] <= PW'(q_in.item.origin_z[POS_FRAC_BITS-1:0]);
				neg_q  <= {q_in.item.dir_z[DirW-1], q_in.item.dir_y[DirW-1],
				           q_in.item.dir_x[DirW-1]};
				mag_q[0] <= q_in.item.dir_x[DirW-1] ? DirW'(~q_in.item.dir_x + 1'b1)
				                                   : q_in.item.dir_x;
				mag_q[1] <= q_in.item.dir_y[DirW-1] ? DirW'(~q_in.item.dir_y + 1'b1)
				                                   : q_in.item.dir_y;
				mag_q[2] <= q_in.item.dir_z[DirW-1] ? DirW'(~q_in.item.dir_z + 1'b1)
				                                   : q_in.item.dir_z;
				maxd_q <= q_in.item.max_dist;
				lim_q  <= LimW'(({2'b00, q_in.item.max_dist}
				          + {1'b0, q_in.item.max_dist, 1'b0}) >> 8);
				sq_q   <= '0;
				trav_q <= '0;
				i_q    <= '0;
				ax_q   <= 2'd0;
			end
			ST_SQ: begin
				sq_q <= sq_q + 32'(mag_q[axi]) * 32'(mag_q[axi]);
				ax_q <= ax_q + 2'd1;
				r_q   <= '0;
				bit_q <= 32'd1 << 30;
			end
			ST_SQRT: begin
				if (sq_q >= sq_sum) begin
					sq_q <= sq_q - sq_sum;
					r_q  <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			ST_LOOP: begin
				dlen_q <= DistW'(r_q);
				rem_q  <= RemInit;
				axis_q <= AXIS_NONE;
				ax_q   <= 2'd0;
			end
			ST_AX: begin
				dn_q   <= {gap, {DirFrac{1'b0}}};
				dr_q   <= '0;
				dcnt_q <= CW'(NW);
				if (ax_q != AXIS_NONE && mag_q[axi] == '0) begin
					ax_q <= ax_q + 2'd1;
				end
			end
			ST_DIV: begin
				if (dtry >= {1'b0, mag_q[axi]}) begin
					dr_q <= DirW'(dtry - {1'b0, mag_q[axi]});
					dn_q <= {dn_q[NW-2:0], 1'b1};
				end else begin
					dr_q <= DirW'(dtry);
					dn_q <= {dn_q[NW-2:0], 1'b0};
				end
				dcnt_q <= dcnt_q - 1'b1;
			end
			ST_DIVE: begin
				if (dn_q < NW'(rem_q)) begin
					rem_q  <= RW'(dn_q);
					axis_q <= ax_q;
				end
				ax_q <= ax_q + 2'd1;
			end
			ST_DIST: begin
				trav_q <= trav_n;
				ax_q   <= 2'd0;
			end
			ST_MOVE: begin
				if (ax_q != AXIS_NONE && ax_q != axis_q) begin
					if (neg_q[axi]) begin
						p_q[axi] <= (mv >= MvW'(p_q[axi])) ? '0 : p_q[axi] - PW'(mv);
					end else begin
						p_q[axi] <= (psum > MvW'(OneV)) ? OneV : PW'(psum);
					end
				end
				if (ax_q != AXIS_NONE) begin
					ax_q <= ax_q + 2'd1;
				end
			end
			ST_CROSS: begin
				if (neg_q[axc]) begin
					cur_q[axc] <= cur_q[axc] - 1'b1;
					p_q[axc]   <= OneV;
				end else begin
					cur_q[axc] <= cur_q[axc] + 1'b1;
					p_q[axc]   <= '0;
				end
			end
			ST_RD: begin
				ingrid_q <= ingrid_c;
				z_q      <= XW'(unsigned'(cur_q[2][XW-1:0]));
			end
			ST_CHECK: begin
				i_q <= i_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			done     <= 1'b0;
			hit      <= 1'b0;
			hit_side <= SIDE_MISS;
			hit_x    <= '0;
			hit_y    <= '0;
			hit_z    <= '0;
			distance <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(RowN - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_in.valid) begin
						if (q_in.item.is_cast) begin
							state_q <= ST_SQ;
						end else if (q_in.item.wr_ok) begin
							state_q <= ST_W_RD;
						end
					end
				end
				ST_W_RD: begin
					state_q <= ST_W_WR;
				end
				ST_W_WR: begin
					state_q <= ST_IDLE;
				end
				ST_SQ: begin
					if (ax_q == 2'd2) begin
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (bit_q == 32'd1) begin
						state_q <= ST_LOOP;
					end
				end
				ST_LOOP: begin
					if (i_q >= lim_q) begin
						state_q  <= ST_IDLE;
						done     <= 1'b1;
						hit      <= 1'b0;
						hit_side <= SIDE_MISS;
						hit_x    <= '0;
						hit_y    <= '0;
						hit_z    <= '0;
						distance <= '0;
					end else begin
						state_q <= ST_AX;
					end
				end
				ST_AX: begin
					if (ax_q == AXIS_NONE) begin
						state_q <= ST_DIST;
					end else if (mag_q[axi] != '0) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (dcnt_q == CW'(1)) begin
						state_q <= ST_DIVE;
					end
				end
				ST_DIVE: begin
					state_q <= ST_AX;
				end
				ST_DIST: begin
					if (axis_q == AXIS_NONE || trav_n > {1'b0, maxd_q}) begin
						state_q  <= ST_IDLE;
						done     <= 1'b1;
						hit      <= 1'b0;
						hit_side <= SIDE_MISS;
						hit_x    <= '0;
						hit_y    <= '0;
						hit_z    <= '0;
						distance <= '0;
					end else begin
						state_q <= ST_MOVE;
					end
				end
				ST_MOVE: begin
					if (ax_q == AXIS_NONE) begin
						state_q <= ST_CROSS;
					end
				end
				ST_CROSS: begin
					state_q <= ST_RD;
				end
				ST_RD: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (ingrid_q && ram_rdata[z_q]) begin
						state_q  <= ST_IDLE;
						done     <= 1'b1;
						hit      <= 1'b1;
						hit_side <= {axc, neg_q[axc]};
						hit_x    <= CoordW'(unsigned'(cur_q[0]));
						hit_y    <= CoordW'(unsigned'(cur_q[1]));
						hit_z    <= CoordW'(unsigned'(cur_q[2]));
						distance <= DistW'(trav_q);
					end else begin
						state_q <= ST_LOOP;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: src/voxel_grid_ray_traversal.sv
// Top level of the voxel grid ray traversal block.
//
// After reset the grid is swept clear, one row of GRID_SIZE cells per cycle, so busy stays
// high until the whole grid is clear and no command transfer is taken before then. A voxel
// write reads and rewrites its grid row in the walker and gives no result. A cast first
// finds the direction length by a bit-pair square root and then, per cell stepped, runs up
// to three face-distance divisions on the shared serial divider, one per nonzero direction
// axis, together with axis setup, update and grid read. The result appears for one cycle
// with done high and cannot be held off. A two-entry queue in front of the walker takes new
// commands while it works.
module voxel_grid_ray_traversal #(
	parameter int GRID_SIZE     = 64,
	parameter int POS_FRAC_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               action,
	input  logic [vgrt_pkg::CoordW-1:0]        voxel_x,
	input  logic [vgrt_pkg::CoordW-1:0]        voxel_y,
	input  logic [vgrt_pkg::CoordW-1:0]        voxel_z,
	input  logic                               voxel_filled,
	input  logic [vgrt_pkg::OriginW-1:0]       origin_x,
	input  logic [vgrt_pkg::OriginW-1:0]       origin_y,
	input  logic [vgrt_pkg::OriginW-1:0]       origin_z,
	input  logic signed [vgrt_pkg::DirW-1:0]   dir_x,
	input  logic signed [vgrt_pkg::DirW-1:0]   dir_y,
	input  logic signed [vgrt_pkg::DirW-1:0]   dir_z,
	input  logic [vgrt_pkg::DistW-1:0]         max_dist,
	output logic                               done,
	output logic                               hit,
	output logic [vgrt_pkg::SideW-1:0]         hit_side,
	output logic [vgrt_pkg::CoordW-1:0]        hit_x,
	output logic [vgrt_pkg::CoordW-1:0]        hit_y,
	output logic [vgrt_pkg::CoordW-1:0]        hit_z,
	output logic [vgrt_pkg::DistW-1:0]         distance
);

	import vgrt_pkg::*;

	item_t      item_in;
	queue_out_t q_out;
	logic       pop;
	logic       clearing;

	always_comb begin
		item_in              = '0;
		item_in.is_cast      = action;
		item_in.voxel_x      = voxel_x;
		item_in.voxel_y      = voxel_y;
		item_in.voxel_z      = voxel_z;
		item_in.voxel_filled = voxel_filled;
		item_in.origin_x     = origin_x;
		item_in.origin_y     = origin_y;
		item_in.origin_z     = origin_z;
		item_in.dir_x        = dir_x;
		item_in.dir_y        = dir_y;
		item_in.dir_z        = dir_z;
		item_in.max_dist     = max_dist;
	end

	vgrt_front #(
		.GRID_SIZE(GRID_SIZE)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.item_in (item_in),
		.clearing(clearing),
		.pop     (pop),
		.busy    (busy),
		.q_out   (q_out)
	);

	vgrt_back #(
		.GRID_SIZE    (GRID_SIZE),
		.POS_FRAC_BITS(POS_FRAC_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_in    (q_out),
		.pop     (pop),
		.clearing(clearing),
		.done    (done),
		.hit     (hit),
		.hit_side(hit_side),
		.hit_x   (hit_x),
		.hit_y   (hit_y),
		.hit_z   (hit_z),
		.distance(distance)
	);

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the voxel grid ray traversal block.
`timescale 1ns / 1ps

module tb;
	import vgrt_pkg::*;

	localparam int          GridN  = 64;
	localparam int          FracB  = 16;
	localparam longint      CycMax = 50000000;
	localparam logic        ACT_WRITE = 1'b0;
	localparam logic        ACT_CAST  = 1'b1;

	typedef struct {
		logic               act;
		logic [CoordW-1:0]  vx, vy, vz;
		logic               fill;
		logic [OriginW-1:0] ox, oy, oz;
		logic [DirW-1:0]    dx, dy, dz;
		logic [DistW-1:0]   md;
		bit                 hold;
	} cmd_t;

	typedef struct {
		logic               hit;
		logic [SideW-1:0]   side;
		logic [CoordW-1:0]  x, y, z;
		logic [DistW-1:0]   dst;
	} ray_res_t;

	logic clk, arst_n, start, busy, done;
	logic action, voxel_filled, hit;
	logic [CoordW-1:0] voxel_x, voxel_y, voxel_z, hit_x, hit_y, hit_z;
	logic [OriginW-1:0] origin_x, origin_y, origin_z;
	logic signed [DirW-1:0] dir_x, dir_y, dir_z;
	logic [DistW-1:0] max_dist, distance;
	logic [SideW-1:0] hit_side;

	bit       occ [0:GridN*GridN*GridN-1];
	cmd_t     pending_cmds[$];
	ray_res_t expected_rays[$];
	int       issued_count, accepted_count, idle_left;
	int       err_count, cast_count, write_count, hit_count, miss_count;
	longint   cycles;

	voxel_grid_ray_traversal dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .voxel_x(voxel_x), .voxel_y(voxel_y), .voxel_z(voxel_z),
		.voxel_filled(voxel_filled), .origin_x(origin_x), .origin_y(origin_y),
		.origin_z(origin_z), .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
		.max_dist(max_dist), .done(done), .hit(hit), .hit_side(hit_side),
		.hit_x(hit_x), .hit_y(hit_y), .hit_z(hit_z), .distance(distance)
	);

	always begin
		clk = 1'b1; #4;
		clk = 1'b0; #4;
	end

	function automatic int unsigned int_sqrt(int unsigned v);
		int unsigned r, b;
		r = 0;
		b = 32'h4000_0000;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic bit occupied(longint cx, longint cy, longint cz);
		if (cx < 0 || cx >= GridN || cy < 0 || cy >= GridN || cz < 0 || cz >= GridN)
			return 1'b0;
		return occ[(cx * GridN + cy) * GridN + cz];
	endfunction

	function automatic ray_res_t trace_ray(cmd_t c);
		ray_res_t          r;
		longint unsigned   one, p[3], mag[3], trav, lim, rem, gap, t, mv;
		longint            cur[3];
		bit                neg[3];
		int unsigned       sq, dlen;
		logic [OriginW-1:0] o[3];
		logic [DirW-1:0]   d[3];
		int                ax;
		one = 64'd1 << FracB;
		o[0] = c.ox; o[1] = c.oy; o[2] = c.oz;
		d[0] = c.dx; d[1] = c.dy; d[2] = c.dz;
		sq = 0;
		for (int a = 0; a < 3; a++) begin
			cur[a] = o[a] >> FracB;
			p[a]   = o[a] & (one - 1);
			neg[a] = d[a][DirW-1];
			mag[a] = neg[a] ? (64'h10000 - d[a]) : d[a];
			sq     = sq + int'(mag[a] * mag[a]);
		end
		dlen = int_sqrt(sq);
		lim  = (longint'(c.md) * 3) >> 8;
		trav = 0;
		r = '{hit: 1'b0, side: SIDE_MISS, x: '0, y: '0, z: '0, dst: '0};
		for (longint unsigned i = 0; i < lim; i++) begin
			rem = 64'd5 << FracB;
			ax  = -1;
			for (int a = 0; a < 3; a++) begin
				if (mag[a] != 0) begin
					gap = neg[a] ? p[a] : one - p[a];
					t   = (gap << DirFrac) / mag[a];
					if (t < rem) begin
						rem = t;
						ax  = a;
					end
				end
			end
			trav += (rem * dlen) >> (FracB + DirFrac - 8);
			if (ax < 0 || trav > c.md) break;
			for (int a = 0; a < 3; a++) begin
				if (a != ax) begin
					mv = (rem * mag[a]) >> DirFrac;
					if (neg[a]) p[a] = (mv >= p[a]) ? 0 : p[a] - mv;
					else p[a] = (p[a] + mv > one) ? one : p[a] + mv;
				end
			end
			if (neg[ax]) begin
				cur[ax] -= 1; p[ax] = one;
			end else begin
				cur[ax] += 1; p[ax] = 0;
			end
			if (occupied(cur[0], cur[1], cur[2])) begin
				r.hit  = 1'b1;
				r.side = SideW'(ax * 2 + neg[ax]);
				r.x    = CoordW'(cur[0]);
				r.y    = CoordW'(cur[1]);
				r.z    = CoordW'(cur[2]);
				r.dst  = (trav > 64'hFFFF) ? 16'hFFFF : DistW'(trav);
				return r;
			end
		end
		return r;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
		err_count++;
	endtask

	task automatic queue_cmd(cmd_t c);
		pending_cmds.insert(pending_cmds.size(), c);
	endtask

	// accept transfers, predict, and check results
	always @(posedge clk) begin
		ray_res_t e;
		cmd_t     c;
		if (arst_n && done) begin
			if (expected_rays.size() == 0) begin
				report("unexpected result", 1, 0);
			end else begin
				e = expected_rays.pop_front();
				if (hit !== e.hit) report("hit", hit, e.hit);
				if (hit_side !== e.side) report("hit_side", hit_side, e.side);
				if (hit_x !== e.x) report("hit_x", hit_x, e.x);
				if (hit_y !== e.y) report("hit_y", hit_y, e.y);
				if (hit_z !== e.z) report("hit_z", hit_z, e.z);
				if (distance !== e.dst) report("distance", distance, e.dst);
				if (e.hit) hit_count++;
				else miss_count++;
			end
		end
		if (arst_n && start && !busy) begin
			c = '{act: action, vx: voxel_x, vy: voxel_y, vz: voxel_z, fill: voxel_filled,
				ox: origin_x, oy: origin_y, oz: origin_z, dx: dir_x, dy: dir_y, dz: dir_z,
				md: max_dist, hold: 1'b0};
			if (c.act == ACT_WRITE) begin
				occ[(int'(c.vx) * GridN + c.vy) * GridN + c.vz] = c.fill;
				write_count++;
			end else begin
				expected_rays.insert(expected_rays.size(), trace_ray(c));
				cast_count++;
			end
			accepted_count++;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// drive commands on the falling edge
	always @(negedge clk) begin
		bit   go;
		cmd_t c;
		go = 1'b0;
		if (arst_n && !(start && accepted_count != issued_count)) begin
			if (idle_left > 0) begin
				idle_left--;
			end else if (pending_cmds.size() != 0 &&
				!(pending_cmds[0].hold && expected_rays.size() != 0)) begin
				c = pending_cmds.pop_front();
				go = 1'b1;
				action <= c.act; voxel_x <= c.vx; voxel_y <= c.vy; voxel_z <= c.vz;
				voxel_filled <= c.fill; origin_x <= c.ox; origin_y <= c.oy;
				origin_z <= c.oz; dir_x <= c.dx; dir_y <= c.dy; dir_z <= c.dz;
				max_dist <= c.md;
				issued_count++;
				idle_left = pick_gap();
			end
			start <= go;
		end else if (arst_n) begin
			start <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycMax) begin
			$display("timeout after %0d cycles", cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic cmd_t wr_cmd(int x, int y, int z, bit f);
		cmd_t c;
		c = '{act: ACT_WRITE, vx: CoordW'(x), vy: CoordW'(y), vz: CoordW'(z), fill: f,
			ox: OriginW'($urandom), oy: OriginW'($urandom), oz: OriginW'($urandom),
			dx: DirW'($urandom), dy: DirW'($urandom), dz: DirW'($urandom),
			md: DistW'($urandom), hold: 1'b0};
		return c;
	endfunction

	function automatic cmd_t cast_cmd(int ox, int oy, int oz, int dx, int dy, int dz, int md);
		cmd_t c;
		c = '{act: ACT_CAST, vx: CoordW'($urandom), vy: CoordW'($urandom),
			vz: CoordW'($urandom), fill: 1'($urandom),
			ox: OriginW'(ox), oy: OriginW'(oy), oz: OriginW'(oz),
			dx: DirW'(dx), dy: DirW'(dy), dz: DirW'(dz), md: DistW'(md), hold: 1'b0};
		return c;
	endfunction

	function automatic int near_pos();
		return $urandom_range(0, (12 << FracB) - 1);
	endfunction

	function automatic int rand_dir();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 0;
		if (r == 1) return $urandom_range(0, 1) ? 32767 : -32768;
		return $signed(16'($urandom));
	endfunction

	function automatic int rand_md();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85) return $urandom_range(0, 1024);
		if (r < 99) return $urandom_range(1025, 4096);
		return $urandom_range(4097, 16384);
	endfunction

	initial begin
		cmd_t c;
		arst_n = 1'b0; start = 1'b0; action = 1'b0;
		voxel_x = '0; voxel_y = '0; voxel_z = '0; voxel_filled = 1'b0;
		origin_x = '0; origin_y = '0; origin_z = '0;
		dir_x = '0; dir_y = '0; dir_z = '0; max_dist = '0;
		issued_count = 0; accepted_count = 0; idle_left = 0; cycles = 0;
		err_count = 0; cast_count = 0; write_count = 0; hit_count = 0; miss_count = 0;

		// directed: extremes, faces, ties, outside cells, zero direction
		queue_cmd(wr_cmd(0, 0, 0, 1));
		queue_cmd(wr_cmd(63, 63, 63, 1));
		queue_cmd(wr_cmd(2, 2, 0, 1));
		queue_cmd(cast_cmd(32'h18000, 32'h8000, 32'h8000, -16384, 0, 0, 1024));
		queue_cmd(cast_cmd(62 << 16 | 32'h8000, 63 << 16, 63 << 16,
			32767, 0, 0, 1024));
		queue_cmd(cast_cmd(63 << 16, 63 << 16, 63 << 16 | 32'hFFFF,
			0, 0, 32767, 65535));
		queue_cmd(cast_cmd(1 << 16, 0, 0, -32768, 0, 0, 512));
		queue_cmd(cast_cmd(32'h18000, 32'h18000, 32'h8000, 8000, 8000, 0, 2048));
		queue_cmd(cast_cmd(5 << 16, 5 << 16, 5 << 16, 0, 0, 0, 65535));
		queue_cmd(cast_cmd(32'h8000, 32'h8000, 32'h8000, 100, 100, 100, 0));
		queue_cmd(cast_cmd(32'h3FFFFF, 32'h3FFFFF, 32'h3FFFFF,
			-32768, -32768, -32768, 65535));
		queue_cmd(cast_cmd(32'h3FFFFF, 0, 32'h8000, 16384, -16384, 0, 300));
		queue_cmd(wr_cmd(0, 0, 0, 0));
		c = cast_cmd(32'h18000, 32'h8000, 32'h8000, -16384, 0, 0, 1024);
		c.hold = 1'b1;
		queue_cmd(c);
		queue_cmd(cast_cmd(2 << 16 | 32'h8000, 2 << 16 | 32'h8000, 32'h10000,
			0, 0, -16384, 65535));

		// random: writes mostly in a dense neighborhood, mixed with casts mostly from inside it
		for (int i = 0; i < 390; i++) begin
			if ($urandom_range(0, 99) < 35) begin
				if ($urandom_range(0, 9) == 0)
					c = wr_cmd($urandom_range(0, 63), $urandom_range(0, 63),
						$urandom_range(0, 63), $urandom_range(0, 1));
				else
					c = wr_cmd($urandom_range(0, 11), $urandom_range(0, 11),
						$urandom_range(0, 11), $urandom_range(0, 3) != 0);
			end else if ($urandom_range(0, 9) == 0) begin
				c = cast_cmd($urandom_range(0, 32'h3FFFFF), $urandom_range(0, 32'h3FFFFF),
					$urandom_range(0, 32'h3FFFFF), rand_dir(), rand_dir(), rand_dir(),
					rand_md());
			end else begin
				c = cast_cmd(near_pos(), near_pos(), near_pos(), rand_dir(), rand_dir(),
					rand_dir(), rand_md());
			end
			c.hold = (i % 97 == 50);
			queue_cmd(c);
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_cmds.size() != 0 || accepted_count != issued_count
			|| expected_rays.size() != 0) begin
			@(posedge clk);
		end
		repeat (200) @(posedge clk);
		$display("covered %0d voxel writes and %0d casts (%0d hits, %0d misses)",
			write_count, cast_count, hit_count, miss_count);
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("mismatches: %0d", err_count);
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
